>>> src/urhr_pkg.sv
// Package for the undo/redo history ring: sizes, operation codes, payload structs
// and the ring index helper. Depends on nothing; the top level and testbench use it.
package urhr_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 7;
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_UNDO   = 2'd1;
	localparam logic [1:0] OP_REDO   = 2'd2;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [DATA_WIDTH-1:0] value_in;
	} cmd_t;

	typedef struct packed {
		logic                  done_res;
		logic [DATA_WIDTH-1:0] value_out;
		logic [CNT_W-1:0]      entry_count;
		logic                  can_undo;
		logic                  can_redo;
	} rsp_t;

	// Physical slot of a logical position. Both operands are below cap, so the
	// sum is below twice cap and one compare and subtract wraps it.
	function automatic logic [ADDR_W-1:0] wrap_add(
		input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b,
		input logic [CNT_W-1:0] cap
	);
		logic [CNT_W:0] sum;
		logic [CNT_W:0] cap_x;
		logic [CNT_W:0] res;
		sum   = {1'b0, a} + {1'b0, b};
		cap_x = {1'b0, cap};
		res   = (sum >= cap_x) ? (sum - cap_x) : sum;
		return res[ADDR_W-1:0];
	endfunction

endpackage

>>> src/urhr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the snapshot store of the history ring; depends on nothing.
module urhr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// Read data holds while no read is requested.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/undo_redo_history_ring_top.sv
// Top level of the bounded undo/redo history ring.
// Depends on urhr_pkg (types, sizes, ring helper) and urhr_ram (snapshot store).
//
// Usage:
// The command channel (cmd_valid, cmd_ready, cmd) carries one transaction per
// operation: record a snapshot word, undo or redo. The response channel
// (rsp_valid, rsp_ready, rsp) returns exactly one transaction per command, in
// order, with the success flag, the restored word, the live entry count and
// the can-undo and can-redo flags as they stand after the operation.
// The response is registered and is presented in the cycle after its command
// is accepted. Throughput is one command per cycle while responses are taken;
// the pointer update and the single snapshot store access both complete in the
// accepting cycle, and the store's registered read port supplies the word.
// When the receiver stalls, the response register holds its transaction and
// the store's read data holds too; cmd_ready drops until the response is
// taken, and rises again in the cycle in which rsp_ready is seen.
// cfg_we and cfg_wdata write the capacity register; the user must write it only
// while no command is in flight, as the block does not enforce this. Any write
// empties the history. Zero counts as one; values over the ring depth saturate.
// Reset (arst_n low) empties the history, sets the capacity to the full depth
// and drops rsp_valid. No clearing pass is needed: only written slots are read.
module undo_redo_history_ring_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  urhr_pkg::cmd_t             cmd,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output urhr_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [urhr_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int AW = urhr_pkg::ADDR_W;
	localparam int CW = urhr_pkg::CNT_W;

	// Architectural state of the ring.
	logic [urhr_pkg::CAP_W-1:0] capacity_q;
	logic [AW-1:0]              oldest_q;
	logic [CW-1:0]              count_q;
	logic [AW-1:0]              cursor_q;

	// Response register.
	logic                       rsp_valid_q;
	logic                       done_q;
	logic                       rd_hit_q;
	logic [CW-1:0]              rsp_count_q;
	logic                       can_undo_q;
	logic                       can_redo_q;

	logic [CW-1:0]              cap_eff;
	logic [urhr_pkg::CMP_W-1:0] cap_wide;
	logic                       cmd_fire;

	logic [AW-1:0]              oldest_n;
	logic [CW-1:0]              count_n;
	logic [AW-1:0]              cursor_n;
	logic                       done_n;
	logic                       can_undo_n;
	logic                       can_redo_n;
	logic [CW-1:0]              cursor_inc;
	logic [CW-1:0]              count_trim;
	logic [CW-1:0]              count_base;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [urhr_pkg::DATA_WIDTH-1:0] ram_rdata;

	// Effective capacity: zero counts as one, anything above the depth saturates.
	always_comb begin
		cap_wide = urhr_pkg::CMP_W'(capacity_q);
		if (cap_wide == '0) begin
			cap_eff = CW'(1);
		end else if (cap_wide > urhr_pkg::CMP_W'(urhr_pkg::DEPTH)) begin
			cap_eff = CW'(urhr_pkg::DEPTH);
		end else begin
			cap_eff = cap_wide[CW-1:0];
		end
	end

	// A new command may enter whenever the response register is free or being emptied.
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign cmd_fire  = cmd_valid && cmd_ready;

	assign cursor_inc = CW'(cursor_q) + CW'(1);

	always_comb begin
		oldest_n   = oldest_q;
		count_n    = count_q;
		cursor_n   = cursor_q;
		done_n     = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = '0;
		ram_raddr  = '0;
		count_trim = count_q;
		count_base = count_q;
		case (cmd.opcode)
			urhr_pkg::OP_RECORD: begin
				// Drop the redo tail, then evict the oldest entry if the ring is full.
				count_trim = (count_q > cursor_inc) ? cursor_inc : count_q;
				if (count_trim >= cap_eff) begin
					oldest_n   = urhr_pkg::wrap_add(CW'(oldest_q), CW'(1), cap_eff);
					count_base = cap_eff - CW'(1);
				end else begin
					count_base = count_trim;
				end
				ram_we    = 1'b1;
				ram_waddr = urhr_pkg::wrap_add(CW'(oldest_n), count_base, cap_eff);
				count_n   = count_base + CW'(1);
				cursor_n  = count_base[AW-1:0];
				done_n    = 1'b1;
			end
			urhr_pkg::OP_UNDO: begin
				if (count_q != '0 && cursor_q != '0) begin
					cursor_n  = cursor_q - AW'(1);
					ram_re    = 1'b1;
					ram_raddr = urhr_pkg::wrap_add(CW'(oldest_q), CW'(cursor_n), cap_eff);
					done_n    = 1'b1;
				end
			end
			urhr_pkg::OP_REDO: begin
				if (count_q != '0 && cursor_inc < count_q) begin
					cursor_n  = cursor_inc[AW-1:0];
					ram_re    = 1'b1;
					ram_raddr = urhr_pkg::wrap_add(CW'(oldest_q), cursor_inc, cap_eff);
					done_n    = 1'b1;
				end
			end
			default: begin
				// The unused code changes nothing and reports failure.
			end
		endcase
		can_undo_n = (count_n != '0) && (cursor_n != '0);
		can_redo_n = (count_n != '0) && ((CW'(cursor_n) + CW'(1)) < count_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= urhr_pkg::CAP_W'(urhr_pkg::DEPTH);
			oldest_q   <= '0;
			count_q    <= '0;
			cursor_q   <= '0;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
			oldest_q   <= '0;
			count_q    <= '0;
			cursor_q   <= '0;
		end else if (cmd_fire) begin
			oldest_q   <= oldest_n;
			count_q    <= count_n;
			cursor_q   <= cursor_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			done_q      <= done_n;
			rd_hit_q    <= ram_re;
			rsp_count_q <= count_n;
			can_undo_q  <= can_undo_n;
			can_redo_q  <= can_redo_n;
		end
	end

	urhr_ram #(
		.WIDTH (urhr_pkg::DATA_WIDTH),
		.DEPTH (urhr_pkg::DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we && cmd_fire),
		.waddr (ram_waddr),
		.wdata (cmd.value_in),
		.re    (ram_re && cmd_fire),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp_valid         = rsp_valid_q;
	assign rsp.done_res      = done_q;
	assign rsp.value_out     = rd_hit_q ? ram_rdata : '0;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.can_undo      = can_undo_q;
	assign rsp.can_redo      = can_redo_q;

	// The live count never exceeds the effective capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff)
		else $error("live count above capacity");

	// The cursor stays inside the live entries, and at zero when the ring is empty.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) ? (cursor_q == '0) : (CW'(cursor_q) < count_q))
		else $error("cursor outside live entries");

	// The oldest slot always lies within the capacity in use.
	a_oldest_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(oldest_q) < cap_eff)
		else $error("oldest slot beyond capacity");

	// An accepted record is answered next cycle with success and a non-empty ring.
	a_record_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && !cfg_we && cmd.opcode == urhr_pkg::OP_RECORD |=>
		rsp_valid && rsp.done_res && rsp.entry_count != '0)
		else $error("record not reported as done");

	// A store read is only ever issued for a successful undo or redo.
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rd_hit_q |-> done_q)
		else $error("store read without a successful step");

endmodule

>>> tb/undo_redo_history_ring_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for undo_redo_history_ring_top: directed table, then random phases.
// Depends on urhr_pkg and the RTL of the history ring; it needs no other file.
module undo_redo_history_ring_top_tb;
	import urhr_pkg::*;

	// Opcode 3 is not used by the block. It must change nothing and report failure.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int PLAN_LEN    = 26;
	localparam int PHASES      = 10;
	localparam int RUN_ITEMS   = 45;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	// One row of the directed table. A configuration row uses only cap. A command row
	// with pinned set carries its expected response, written out by hand; the others
	// are checked against the predictor.
	typedef struct packed {
		row_kind_t             kind;
		logic [1:0]            op;
		logic [DATA_WIDTH-1:0] word;
		logic [CAP_W-1:0]      cap;
		logic                  pinned;
		logic                  w_done;
		logic [DATA_WIDTH-1:0] w_value;
		logic [CNT_W-1:0]      w_count;
		logic                  w_undo;
		logic                  w_redo;
	} row_t;

	// The table begins on an empty ring, walks the cursor to both ends and past them,
	// drops a redo tail, then forces a one-slot ring (capacity zero), an oversized
	// capacity and a two-slot ring that wraps and evicts.
	row_t plan [PLAN_LEN] = '{
		'{ROW_CMD, OP_UNDO,   32'h0000_0000, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_REDO,   32'h0000_0000, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_SPARE,  32'hFFFF_FFFF, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'h0000_0000, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd1, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'hFFFF_FFFF, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd2, 1'b1, 1'b0},
		'{ROW_CMD, OP_UNDO,   32'hFFFF_FFFF, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd2, 1'b0, 1'b1},
		'{ROW_CMD, OP_UNDO,   32'h0000_0000, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd2, 1'b0, 1'b1},
		'{ROW_CMD, OP_REDO,   32'h0000_0000, 7'd0,   1'b1, 1'b1, 32'hFFFF_FFFF, 7'd2, 1'b1, 1'b0},
		'{ROW_CMD, OP_REDO,   32'h0000_0000, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd2, 1'b1, 1'b0},
		'{ROW_CMD, OP_UNDO,   32'h0000_0000, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd2, 1'b0, 1'b1},
		'{ROW_CMD, OP_RECORD, 32'hA5A5_A5A5, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd2, 1'b1, 1'b0},
		'{ROW_CMD, OP_REDO,   32'h0000_0000, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd2, 1'b1, 1'b0},
		'{ROW_CFG, OP_RECORD, 32'h0000_0000, 7'd0,   1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_SPARE,  32'h0000_0000, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'h5A5A_5A5A, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd1, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'h1234_5678, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd1, 1'b0, 1'b0},
		'{ROW_CMD, OP_UNDO,   32'h0000_0000, 7'd0,   1'b1, 1'b0, 32'h0000_0000, 7'd1, 1'b0, 1'b0},
		'{ROW_CFG, OP_RECORD, 32'h0000_0000, 7'd127, 1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'hDEAD_BEEF, 7'd0,   1'b1, 1'b1, 32'h0000_0000, 7'd1, 1'b0, 1'b0},
		'{ROW_CFG, OP_RECORD, 32'h0000_0000, 7'd2,   1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'h0000_0001, 7'd0,   1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'h0000_0002, 7'd0,   1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_RECORD, 32'h0000_0003, 7'd0,   1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_UNDO,   32'h0000_0000, 7'd0,   1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CMD, OP_REDO,   32'h0000_0000, 7'd0,   1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0},
		'{ROW_CFG, OP_RECORD, 32'h0000_0000, 7'd64,  1'b0, 1'b0, 32'h0000_0000, 7'd0, 1'b0, 1'b0}
	};

	// Capacity of each random phase: full depth, one slot, the raw extremes zero and
	// 127, and a value just past the depth, with small rings between them.
	int unsigned phase_cap [PHASES] = '{64, 1, 5, 127, 2, 64, 33, 0, 65, 64};

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_ready;
	cmd_t             cmd       = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b1;
	rsp_t             rsp;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	// Sideband that travels with each command transaction: a hand-written expectation
	// that replaces the predicted one when pin_set is high.
	logic pin_set = 1'b0;
	rsp_t pin_rsp = '0;

	// Chance, in percent, that the sender inserts a gap or the receiver a stall.
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;

	// Predictor state: the ring contents, the oldest slot, the live count, the cursor
	// and the raw capacity register as last written.
	logic [DATA_WIDTH-1:0] hist_word [DEPTH];
	int unsigned           hist_oldest = 0;
	int unsigned           hist_count  = 0;
	int unsigned           hist_cursor = 0;
	logic [CAP_W-1:0]      cap_reg     = 7'd64;

	rsp_t        pending_q [$];
	int unsigned fault_count = 0;

	undo_redo_history_ring_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one command to the predictor and returns the response it should give.
	// Zero capacity counts as one slot and anything above the depth as the depth.
	function automatic rsp_t history_step(input cmd_t c);
		rsp_t        r;
		int unsigned slots;
		slots = (cap_reg == 0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
		r = '0;
		case (c.opcode)
		OP_RECORD: begin
			// A record discards the redo tail, then evicts the oldest entry if full.
			if (hist_count > hist_cursor + 1)
				hist_count = hist_cursor + 1;
			if (hist_count >= slots) begin
				hist_oldest = (hist_oldest + 1) % slots;
				hist_count  = slots - 1;
			end
			hist_word[ADDR_W'((hist_oldest + hist_count) % slots)] = c.value_in;
			hist_count++;
			hist_cursor = hist_count - 1;
			r.done_res  = 1'b1;
		end
		OP_UNDO: begin
			if (hist_count != 0 && hist_cursor != 0) begin
				hist_cursor--;
				r.value_out = hist_word[ADDR_W'((hist_oldest + hist_cursor) % slots)];
				r.done_res  = 1'b1;
			end
		end
		OP_REDO: begin
			if (hist_count != 0 && hist_cursor + 1 < hist_count) begin
				hist_cursor++;
				r.value_out = hist_word[ADDR_W'((hist_oldest + hist_cursor) % slots)];
				r.done_res  = 1'b1;
			end
		end
		default: begin
		end
		endcase
		r.entry_count = CNT_W'(hist_count);
		r.can_undo    = (hist_count > 0) && (hist_cursor > 0);
		r.can_redo    = (hist_count > 0) && (hist_cursor + 1 < hist_count);
		return r;
	endfunction

	task automatic note_fault(input string what, input rsp_t got, input rsp_t want);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%s at %0t: expected done=%0b value=%h count=%0d undo=%0b redo=%0b",
				what, $realtime, want.done_res, want.value_out, want.entry_count,
				want.can_undo, want.can_redo);
			$display("    got done=%0b value=%h count=%0d undo=%0b redo=%0b",
				got.done_res, got.value_out, got.entry_count, got.can_undo,
				got.can_redo);
		end
	endtask

	// Scoreboard. Everything is sampled at the rising edge, before the nonblocking
	// updates of that edge land, so each handshake is seen exactly as the block sees it.
	// A capacity write empties the predicted history; an accepted command is predicted
	// and queued; an accepted response is compared with the oldest queued expectation.
	always @(posedge clk) begin : scoreboard
		rsp_t want;
		if (arst_n) begin
			if (cfg_we) begin
				cap_reg     = cfg_wdata;
				hist_oldest = 0;
				hist_count  = 0;
				hist_cursor = 0;
			end
			if (cmd_valid && cmd_ready) begin
				want = history_step(cmd);
				if (pin_set)
					want = pin_rsp;
				pending_q.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_q.size() == 0) begin
					note_fault("response with nothing outstanding", rsp, '0);
				end else begin
					want = pending_q.pop_front();
					if (rsp.done_res !== want.done_res || rsp.value_out !== want.value_out ||
							rsp.entry_count !== want.entry_count ||
							rsp.can_undo !== want.can_undo || rsp.can_redo !== want.can_redo)
						note_fault("response mismatch", rsp, want);
				end
			end
		end
	end

	// Receiver back-pressure: stalled bursts of random length. A phase with a zero
	// percentage gives a long stretch with rsp_ready held high.
	initial begin : rsp_stall
		int unsigned hold;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				hold = $urandom_range(1, 19);
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
				rsp_ready <= 1'b1;
			end
		end
	end

	// Presents one command transaction and returns at the edge that accepts it. The
	// valid stays high afterwards so that the next command can follow back to back.
	task automatic issue(input cmd_t c, input logic pinned, input rsp_t pin);
		int unsigned gap;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 19);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		pin_set   <= pinned;
		pin_rsp   <= pin;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Stops sending and waits until every expected response has been taken. The first
	// edge is always waited for, so a command accepted at the current edge is counted.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly random words, with the all-zero and all-one words now and then.
	function automatic logic [DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 19))
		0:       return '0;
		1:       return '1;
		default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		cmd_t        c;
		rsp_t        pin;
		int unsigned slots;
		int unsigned prefill;
		int unsigned run_len;
		int unsigned choice;
		logic [1:0]  run_op;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, with moderate idling on both sides.
		gap_pct   = 30;
		stall_pct = 30;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_capacity(plan[i].cap);
			end else begin
				c.opcode        = plan[i].op;
				c.value_in      = plan[i].word;
				pin.done_res    = plan[i].w_done;
				pin.value_out   = plan[i].w_value;
				pin.entry_count = plan[i].w_count;
				pin.can_undo    = plan[i].w_undo;
				pin.can_redo    = plan[i].w_redo;
				issue(c, plan[i].pinned, pin);
			end
		end

		// Random phases. Each one sets a capacity on an idle block, prefills the ring with a
		// run of records, then issues runs of one operation so that the cursor travels
		// deep in both directions; opcode 3 turns up now and then as noise. The first
		// phase overfills the full-depth ring so that the count tops out and evicts.
		// The final phase runs with no idling at all.
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_cap[p][CAP_W-1:0]);
			if (p == PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 15 * $urandom_range(0, 3);
				stall_pct = 15 * $urandom_range(0, 3);
			end
			slots   = (phase_cap[p] == 0) ? 1 : ((phase_cap[p] > DEPTH) ? DEPTH : phase_cap[p]);
			prefill = (p == 0) ? slots + 4 : $urandom_range(slots / 2, slots + 4);
			for (int k = 0; k < prefill; k++) begin
				c.opcode   = OP_RECORD;
				c.value_in = pick_word();
				issue(c, 1'b0, '0);
			end
			run_len = 0;
			run_op  = OP_RECORD;
			for (int k = 0; k < RUN_ITEMS; k++) begin
				if (run_len == 0) begin
					choice  = $urandom_range(0, 99);
					run_op  = (choice < 45) ? OP_RECORD : (choice < 70) ? OP_UNDO :
						(choice < 95) ? OP_REDO : OP_SPARE;
					run_len = $urandom_range(1, 8);
				end
				c.opcode   = run_op;
				c.value_in = pick_word();
				issue(c, 1'b0, '0);
				run_len--;
				// Occasionally let the pipeline run completely dry mid-phase.
				if (p != PHASES - 1 && $urandom_range(0, 49) == 0)
					wait_idle();
			end
		end

		// Drain, then keep clocking so that any stray response still shows up.
		wait_idle();
		repeat (4) @(posedge clk);
		if (fault_count == 0 && pending_q.size() == 0)
			$display("undo_redo_history_ring_top_tb OK");
		else
			$display("undo_redo_history_ring_top_tb NOT OK");
		$finish;
	end

	// Watchdog: a correct run finishes well inside this many cycles.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("undo_redo_history_ring_top_tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
src/urhr_pkg.sv
src/urhr_ram.sv
src/undo_redo_history_ring_top.sv
tb/undo_redo_history_ring_top_tb.sv
